### hw/rtl/blocking_message_channel_macros.svh
// Assertion helpers for the message channel.
`ifndef BLOCKING_MESSAGE_CHANNEL_MACROS_SVH
`define BLOCKING_MESSAGE_CHANNEL_MACROS_SVH

// Condition implies consequence in the same cycle.
`define BMC_ASSERT_SAME(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("channel check failed");

// Condition implies consequence in the following cycle.
`define BMC_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("channel check failed");

`endif

### hw/rtl/bmc_pkg.sv
package bmc_pkg;

  localparam int BUF_DEPTH   = 16;
  localparam int DATA_BYTES  = 8;
  localparam int MAX_THREADS = 16;

  localparam int TID_W  = 4;
  localparam int CAP_W  = 5;
  localparam int PORT_W = 64;
  localparam int DATA_W = 8 * DATA_BYTES;

  localparam int RING_AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int RING_CW = $clog2(BUF_DEPTH + 1);
  localparam int WQ_AW   = $clog2(MAX_THREADS);
  localparam int WQ_CW   = $clog2(MAX_THREADS + 1);
  localparam int CMP_W   = (RING_CW > CAP_W) ? RING_CW : CAP_W;
  localparam int SND_W   = TID_W + DATA_W;

  typedef enum logic [1:0] {
    KIND_DONE     = 2'd0,
    KIND_BLOCK    = 2'd1,
    KIND_WAKE     = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  typedef enum logic {
    OP_SEND = 1'b0,
    OP_RECV = 1'b1
  } op_t;

  typedef struct packed {
    logic [RING_AW-1:0] ring_head;
    logic [RING_AW-1:0] ring_tail;
    logic [RING_CW-1:0] ring_count;
    logic [WQ_AW-1:0]   snd_head;
    logic [WQ_AW-1:0]   snd_tail;
    logic [WQ_CW-1:0]   snd_count;
    logic [WQ_AW-1:0]   rcv_head;
    logic [WQ_AW-1:0]   rcv_tail;
    logic [WQ_CW-1:0]   rcv_count;
  } ptrs_t;

  typedef struct packed {
    logic               ring_we;
    logic [RING_AW-1:0] ring_waddr;
    logic [DATA_W-1:0]  ring_wdata;
    logic               snd_we;
    logic [WQ_AW-1:0]   snd_waddr;
    logic [SND_W-1:0]   snd_wdata;
    logic               rcv_we;
    logic [WQ_AW-1:0]   rcv_waddr;
    logic [TID_W-1:0]   rcv_wdata;
  } wr_t;

  typedef struct packed {
    kind_t             kind;
    logic [TID_W-1:0]  tid;
    logic [DATA_W-1:0] data;
  } res_t;

  typedef struct packed {
    ptrs_t nxt;
    wr_t   wr;
    res_t  first;
    res_t  second;
    logic  two;
    logic  quiet;
  } exec_t;

endpackage

### hw/rtl/bmc_ram.sv
module bmc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                          rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/bmc_exec.sv
// Decides one request from the pointers and the queue heads read from memory.
module bmc_exec (
  input  logic [bmc_pkg::CAP_W-1:0]  capacity,
  input  logic                       op,
  input  logic [bmc_pkg::TID_W-1:0]  tid,
  input  logic [bmc_pkg::DATA_W-1:0] data,
  input  bmc_pkg::ptrs_t             ptrs,
  input  logic [bmc_pkg::DATA_W-1:0] ring_rdata,
  input  logic [bmc_pkg::SND_W-1:0]  snd_rdata,
  input  logic [bmc_pkg::TID_W-1:0]  rcv_rdata,
  output bmc_pkg::exec_t             ex
);

  logic [bmc_pkg::CMP_W-1:0] cap_w;
  logic [bmc_pkg::CMP_W-1:0] cnt_w;
  logic [bmc_pkg::CMP_W-1:0] eff_cap;
  logic                      cap_on;
  logic                      ring_full;
  logic                      ring_empty;
  logic                      snd_full;
  logic                      rcv_full;
  logic                      snd_any;
  logic                      rcv_any;
  logic [bmc_pkg::RING_AW-1:0] ring_head_inc;
  logic [bmc_pkg::RING_AW-1:0] ring_tail_inc;
  logic [bmc_pkg::WQ_AW-1:0]   snd_head_inc;
  logic [bmc_pkg::WQ_AW-1:0]   snd_tail_inc;
  logic [bmc_pkg::WQ_AW-1:0]   rcv_head_inc;
  logic [bmc_pkg::WQ_AW-1:0]   rcv_tail_inc;

  assign cap_w   = bmc_pkg::CMP_W'(capacity);
  assign cnt_w   = bmc_pkg::CMP_W'(ptrs.ring_count);
  assign eff_cap = (cap_w > bmc_pkg::CMP_W'(bmc_pkg::BUF_DEPTH)) ?
                   bmc_pkg::CMP_W'(bmc_pkg::BUF_DEPTH) : cap_w;
  assign cap_on     = (capacity != '0);
  assign ring_full  = (cnt_w >= eff_cap);
  assign ring_empty = (ptrs.ring_count == '0);
  assign snd_full   = (ptrs.snd_count == bmc_pkg::WQ_CW'(bmc_pkg::MAX_THREADS));
  assign rcv_full   = (ptrs.rcv_count == bmc_pkg::WQ_CW'(bmc_pkg::MAX_THREADS));
  assign snd_any    = (ptrs.snd_count != '0);
  assign rcv_any    = (ptrs.rcv_count != '0);

  assign ring_head_inc = (ptrs.ring_head == bmc_pkg::RING_AW'(bmc_pkg::BUF_DEPTH - 1)) ?
                         '0 : ptrs.ring_head + 1'b1;
  assign ring_tail_inc = (ptrs.ring_tail == bmc_pkg::RING_AW'(bmc_pkg::BUF_DEPTH - 1)) ?
                         '0 : ptrs.ring_tail + 1'b1;
  assign snd_head_inc  = (ptrs.snd_head == bmc_pkg::WQ_AW'(bmc_pkg::MAX_THREADS - 1)) ?
                         '0 : ptrs.snd_head + 1'b1;
  assign snd_tail_inc  = (ptrs.snd_tail == bmc_pkg::WQ_AW'(bmc_pkg::MAX_THREADS - 1)) ?
                         '0 : ptrs.snd_tail + 1'b1;
  assign rcv_head_inc  = (ptrs.rcv_head == bmc_pkg::WQ_AW'(bmc_pkg::MAX_THREADS - 1)) ?
                         '0 : ptrs.rcv_head + 1'b1;
  assign rcv_tail_inc  = (ptrs.rcv_tail == bmc_pkg::WQ_AW'(bmc_pkg::MAX_THREADS - 1)) ?
                         '0 : ptrs.rcv_tail + 1'b1;

  always_comb begin
    ex              = '0;
    ex.nxt          = ptrs;
    ex.first.kind   = bmc_pkg::KIND_DONE;
    ex.first.tid    = tid;
    ex.first.data   = '0;
    ex.second.kind  = bmc_pkg::KIND_WAKE;
    ex.second.tid   = '0;
    ex.second.data  = '0;
    ex.two          = 1'b0;
    ex.wr.ring_waddr = ptrs.ring_tail;
    ex.wr.snd_waddr  = ptrs.snd_tail;
    ex.wr.snd_wdata  = {tid, data};
    ex.wr.rcv_waddr  = ptrs.rcv_tail;
    ex.wr.rcv_wdata  = tid;

    if (op == bmc_pkg::OP_SEND) begin
      if ((cap_on && ring_full) || (!cap_on && !rcv_any)) begin
        if (snd_full) begin
          ex.first.kind = bmc_pkg::KIND_OVERFLOW;
        end else begin
          ex.first.kind     = bmc_pkg::KIND_BLOCK;
          ex.wr.snd_we      = 1'b1;
          ex.nxt.snd_tail   = snd_tail_inc;
          ex.nxt.snd_count  = ptrs.snd_count + 1'b1;
        end
      end else if (cap_on) begin
        ex.wr.ring_we    = 1'b1;
        ex.wr.ring_wdata = data;
        ex.nxt.ring_tail = ring_tail_inc;
        ex.nxt.ring_count = ptrs.ring_count + 1'b1;
        if (rcv_any) begin
          // empty ring: the popped entry is the one just pushed
          ex.two            = 1'b1;
          ex.second.tid     = rcv_rdata;
          ex.second.data    = ring_empty ? data : ring_rdata;
          ex.nxt.rcv_head   = rcv_head_inc;
          ex.nxt.rcv_count  = ptrs.rcv_count - 1'b1;
          ex.nxt.ring_head  = ring_head_inc;
          ex.nxt.ring_count = ptrs.ring_count;
        end
      end else begin
        ex.two           = 1'b1;
        ex.second.tid    = rcv_rdata;
        ex.second.data   = data;
        ex.nxt.rcv_head  = rcv_head_inc;
        ex.nxt.rcv_count = ptrs.rcv_count - 1'b1;
      end
    end else begin
      if ((cap_on && ring_empty) || (!cap_on && !snd_any)) begin
        if (rcv_full) begin
          ex.first.kind = bmc_pkg::KIND_OVERFLOW;
        end else begin
          ex.first.kind    = bmc_pkg::KIND_BLOCK;
          ex.wr.rcv_we     = 1'b1;
          ex.nxt.rcv_tail  = rcv_tail_inc;
          ex.nxt.rcv_count = ptrs.rcv_count + 1'b1;
        end
      end else if (cap_on) begin
        ex.first.data     = ring_rdata;
        ex.nxt.ring_head  = ring_head_inc;
        ex.nxt.ring_count = ptrs.ring_count - 1'b1;
        if (snd_any) begin
          // waiting sender refills the slot just freed
          ex.two            = 1'b1;
          ex.second.tid     = snd_rdata[bmc_pkg::SND_W-1 -: bmc_pkg::TID_W];
          ex.wr.ring_we     = 1'b1;
          ex.wr.ring_wdata  = snd_rdata[bmc_pkg::DATA_W-1:0];
          ex.nxt.ring_tail  = ring_tail_inc;
          ex.nxt.ring_count = ptrs.ring_count;
          ex.nxt.snd_head   = snd_head_inc;
          ex.nxt.snd_count  = ptrs.snd_count - 1'b1;
        end
      end else begin
        ex.two           = 1'b1;
        ex.first.data    = snd_rdata[bmc_pkg::DATA_W-1:0];
        ex.second.tid    = snd_rdata[bmc_pkg::SND_W-1 -: bmc_pkg::TID_W];
        ex.nxt.snd_head  = snd_head_inc;
        ex.nxt.snd_count = ptrs.snd_count - 1'b1;
      end
    end

    ex.quiet = (ex.nxt.ring_count == '0) && (ex.nxt.snd_count == '0) &&
               (ex.nxt.rcv_count == '0);
  end

endmodule

### hw/rtl/blocking_message_channel.sv
// Each request is handled as follows: the accept cycle reads the ring and both waiter queue
// heads from memory, the next cycle (busy high) decides and writes back.
// The first result is registered at the end of the busy cycle, a wake result in the cycle after it;
// the next request may be accepted while results are still on the ports.
// Results cannot be stalled. Synchronous reset empties the ring and both queues,
// clears capacity to zero (rendezvous); memory contents are not cleared.
`include "blocking_message_channel_macros.svh"

module blocking_message_channel (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_op,
  input  logic [bmc_pkg::TID_W-1:0]  in_thread_id,
  input  logic [bmc_pkg::PORT_W-1:0] in_send_data,
  output logic                       out_valid,
  output logic [1:0]                 out_kind,
  output logic [bmc_pkg::TID_W-1:0]  out_target_thread,
  output logic [bmc_pkg::PORT_W-1:0] out_recv_data,
  output logic                       out_last,
  output logic                       out_quiescent,
  input  logic                       cfg_we,
  input  logic [bmc_pkg::CAP_W-1:0]  cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT2
  } state_t;

  state_t                     state_r, state_nxt;
  bmc_pkg::ptrs_t             ptrs_r, ptrs_nxt;
  logic [bmc_pkg::CAP_W-1:0]  cap_r, cap_nxt;
  logic                       op_r, op_nxt;
  logic [bmc_pkg::TID_W-1:0]  tid_r, tid_nxt;
  logic [bmc_pkg::DATA_W-1:0] data_r, data_nxt;
  bmc_pkg::res_t              pend_r, pend_nxt;
  logic                       out_valid_r, out_valid_nxt;
  bmc_pkg::res_t              out_res_r, out_res_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_quiet_r, out_quiet_nxt;

  logic                       accept;
  bmc_pkg::exec_t             ex;
  logic [bmc_pkg::DATA_W-1:0] ring_rdata;
  logic [bmc_pkg::SND_W-1:0]  snd_rdata;
  logic [bmc_pkg::TID_W-1:0]  rcv_rdata;

  assign busy   = (state_r == ST_EXEC);
  assign accept = start && !busy;

  bmc_ram #(.Width(bmc_pkg::DATA_W), .Depth(bmc_pkg::BUF_DEPTH)) u_ring (
    .clk   (clk),
    .we    (busy && ex.wr.ring_we),
    .waddr (ex.wr.ring_waddr),
    .wdata (ex.wr.ring_wdata),
    .re    (accept),
    .raddr (ptrs_r.ring_head),
    .rdata (ring_rdata)
  );

  bmc_ram #(.Width(bmc_pkg::SND_W), .Depth(bmc_pkg::MAX_THREADS)) u_snd_q (
    .clk   (clk),
    .we    (busy && ex.wr.snd_we),
    .waddr (ex.wr.snd_waddr),
    .wdata (ex.wr.snd_wdata),
    .re    (accept),
    .raddr (ptrs_r.snd_head),
    .rdata (snd_rdata)
  );

  bmc_ram #(.Width(bmc_pkg::TID_W), .Depth(bmc_pkg::MAX_THREADS)) u_rcv_q (
    .clk   (clk),
    .we    (busy && ex.wr.rcv_we),
    .waddr (ex.wr.rcv_waddr),
    .wdata (ex.wr.rcv_wdata),
    .re    (accept),
    .raddr (ptrs_r.rcv_head),
    .rdata (rcv_rdata)
  );

  bmc_exec u_exec (
    .capacity   (cap_r),
    .op         (op_r),
    .tid        (tid_r),
    .data       (data_r),
    .ptrs       (ptrs_r),
    .ring_rdata (ring_rdata),
    .snd_rdata  (snd_rdata),
    .rcv_rdata  (rcv_rdata),
    .ex         (ex)
  );

  always_comb begin
    state_nxt     = state_r;
    ptrs_nxt      = ptrs_r;
    cap_nxt       = cfg_we ? cfg_wdata : cap_r;
    op_nxt        = op_r;
    tid_nxt       = tid_r;
    data_nxt      = data_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    out_quiet_nxt = out_quiet_r;

    if (accept) begin
      op_nxt   = in_op;
      tid_nxt  = in_thread_id;
      data_nxt = in_send_data[bmc_pkg::DATA_W-1:0];
    end

    case (state_r)
      ST_EXEC: begin
        state_nxt     = ex.two ? ST_OUT2 : ST_IDLE;
        ptrs_nxt      = ex.nxt;
        pend_nxt      = ex.second;
        out_valid_nxt = 1'b1;
        out_res_nxt   = ex.first;
        out_last_nxt  = !ex.two;
        out_quiet_nxt = ex.quiet;
      end
      ST_OUT2: begin
        state_nxt     = accept ? ST_EXEC : ST_IDLE;
        out_valid_nxt = 1'b1;
        out_res_nxt   = pend_r;
        out_last_nxt  = 1'b1;
      end
      default: begin
        state_nxt = accept ? ST_EXEC : ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptrs_r      <= '0;
      cap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptrs_r      <= ptrs_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    tid_r       <= tid_nxt;
    data_r      <= data_nxt;
    pend_r      <= pend_nxt;
    out_res_r   <= out_res_nxt;
    out_last_r  <= out_last_nxt;
    out_quiet_r <= out_quiet_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_res_r.kind;
  assign out_target_thread = out_res_r.tid;
  assign out_recv_data     = bmc_pkg::PORT_W'(out_res_r.data);
  assign out_last          = out_last_r;
  assign out_quiescent     = out_quiet_r;

  `BMC_ASSERT_NEXT(a_exec_single, clk, rst_n, busy, !busy)
  `BMC_ASSERT_NEXT(a_wake_follows, clk, rst_n, out_valid && !out_last, out_valid && out_last)
  `BMC_ASSERT_SAME(a_wake_is_last, clk, rst_n, out_valid && out_kind == bmc_pkg::KIND_WAKE, out_last)
  `BMC_ASSERT_SAME(a_ring_bound, clk, rst_n, 1'b1, ptrs_r.ring_count <= bmc_pkg::RING_CW'(bmc_pkg::BUF_DEPTH))

endmodule

### test/channel_scoreboard.sv
`timescale 1ns / 100ps

module channel_scoreboard
  import bmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic              in_op,
  input  logic [TID_W-1:0]  in_thread_id,
  input  logic [PORT_W-1:0] in_send_data,
  input  logic              out_valid,
  input  logic [1:0]        out_kind,
  input  logic [TID_W-1:0]  out_target_thread,
  input  logic [PORT_W-1:0] out_recv_data,
  input  logic              out_last,
  input  logic              out_quiescent,
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_wdata,
  output int                pending_results,
  output int                mismatch_count
);

  localparam logic [PORT_W-1:0] DATA_MASK =
    (DATA_W >= PORT_W) ? '1 : ((64'd1 << DATA_W) - 64'd1);

  typedef struct packed {
    kind_t             kind;
    logic [TID_W-1:0]  tid;
    logic [PORT_W-1:0] data;
    logic              last;
    logic              quiet;
  } outcome_t;

  outcome_t awaited_results[$];

  logic [CAP_W-1:0]   capacity;

  // ring and queue depths are powers of two, so pointers wrap on their own
  logic [PORT_W-1:0]  ring_msg[BUF_DEPTH];
  logic [RING_AW-1:0] ring_rd, ring_wr;
  logic [RING_CW-1:0] ring_fill;

  logic [TID_W-1:0]   snd_tid[MAX_THREADS];
  logic [PORT_W-1:0]  snd_msg[MAX_THREADS];
  logic [WQ_AW-1:0]   snd_rd, snd_wr;
  logic [WQ_CW-1:0]   snd_fill;

  logic [TID_W-1:0]   rcv_tid[MAX_THREADS];
  logic [WQ_AW-1:0]   rcv_rd, rcv_wr;
  logic [WQ_CW-1:0]   rcv_fill;

  task automatic report_mismatch(string what, logic [PORT_W-1:0] got,
                                 logic [PORT_W-1:0] want);
    $display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic void predict_request(op_t op, logic [TID_W-1:0] me,
                                          logic [PORT_W-1:0] raw);
    logic [PORT_W-1:0] msg;
    logic [CMP_W-1:0]  limit;
    logic              must_wait;
    logic              has_wake;
    logic              quiet;
    outcome_t          first;
    outcome_t          wake;
    msg = raw & DATA_MASK;
    limit = (capacity > BUF_DEPTH) ? CMP_W'(BUF_DEPTH) : CMP_W'(capacity);
    must_wait = 1'b0;
    has_wake = 1'b0;
    first = '{kind: KIND_DONE, tid: me, data: '0, last: 1'b0, quiet: 1'b0};
    wake = first;
    wake.kind = KIND_WAKE;

    if (op == OP_SEND) begin
      if (limit != 0 && ring_fill < limit) begin
        ring_msg[ring_wr] = msg;
        ring_wr++;
        ring_fill++;
        // receivers can be parked with data buffered after a capacity change
        if (rcv_fill != 0) begin
          has_wake = 1'b1;
          wake.tid = rcv_tid[rcv_rd];
          wake.data = ring_msg[ring_rd];
          rcv_rd++;
          rcv_fill--;
          ring_rd++;
          ring_fill--;
        end
      end else if (limit == 0 && rcv_fill != 0) begin
        has_wake = 1'b1;
        wake.tid = rcv_tid[rcv_rd];
        wake.data = msg;
        rcv_rd++;
        rcv_fill--;
      end else begin
        must_wait = 1'b1;
      end
    end else begin
      if (limit != 0 && ring_fill != 0) begin
        first.data = ring_msg[ring_rd];
        ring_rd++;
        ring_fill--;
        if (snd_fill != 0) begin
          has_wake = 1'b1;
          wake.tid = snd_tid[snd_rd];
          ring_msg[ring_wr] = snd_msg[snd_rd];
          ring_wr++;
          ring_fill++;
          snd_rd++;
          snd_fill--;
        end
      end else if (limit == 0 && snd_fill != 0) begin
        has_wake = 1'b1;
        wake.tid = snd_tid[snd_rd];
        first.data = snd_msg[snd_rd];
        snd_rd++;
        snd_fill--;
      end else begin
        must_wait = 1'b1;
      end
    end

    if (must_wait) begin
      if ((op == OP_SEND ? snd_fill : rcv_fill) >= MAX_THREADS) begin
        first.kind = KIND_OVERFLOW;
      end else if (op == OP_SEND) begin
        first.kind = KIND_BLOCK;
        snd_tid[snd_wr] = me;
        snd_msg[snd_wr] = msg;
        snd_wr++;
        snd_fill++;
      end else begin
        first.kind = KIND_BLOCK;
        rcv_tid[rcv_wr] = me;
        rcv_wr++;
        rcv_fill++;
      end
    end

    quiet = (ring_fill == 0) && (snd_fill == 0) && (rcv_fill == 0);
    first.quiet = quiet;
    wake.quiet = quiet;
    first.last = !has_wake;
    wake.last = 1'b1;
    awaited_results.push_back(first);
    if (has_wake) awaited_results.push_back(wake);
  endfunction

  always @(posedge clk) begin
    outcome_t head;
    if (!rst_n) begin
      capacity = '0;
      ring_rd = '0;
      ring_wr = '0;
      ring_fill = '0;
      snd_rd = '0;
      snd_wr = '0;
      snd_fill = '0;
      rcv_rd = '0;
      rcv_wr = '0;
      rcv_fill = '0;
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unrequested result kind", out_kind, '0);
        end else begin
          head = awaited_results.pop_front();
          if (out_kind != head.kind) report_mismatch("kind", out_kind, head.kind);
          if (out_target_thread != head.tid)
            report_mismatch("target_thread", out_target_thread, head.tid);
          if (out_recv_data != head.data)
            report_mismatch("recv_data", out_recv_data, head.data);
          if (out_last != head.last) report_mismatch("last", out_last, head.last);
          if (out_quiescent != head.quiet)
            report_mismatch("quiescent", out_quiescent, head.quiet);
        end
      end
      if (cfg_we) capacity = cfg_wdata;
      if (start && !busy) predict_request(op_t'(in_op), in_thread_id, in_send_data);
    end
    pending_results = awaited_results.size();
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bmc_pkg::*;

  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 135;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_op = OP_SEND;
  logic [TID_W-1:0]   in_thread_id = '0;
  logic [PORT_W-1:0]  in_send_data = '0;
  logic               out_valid;
  logic [1:0]         out_kind;
  logic [TID_W-1:0]   out_target_thread;
  logic [PORT_W-1:0]  out_recv_data;
  logic               out_last;
  logic               out_quiescent;
  logic               cfg_we = 1'b0;
  logic [CAP_W-1:0]   cfg_wdata = '0;
  int                 pending_results;
  int                 mismatch_count;

  logic [CAP_W-1:0]   phase_capacity[NUM_PHASES] = '{0, 16, 1, 31, 3, 0, 17, 8, 2, 0};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  blocking_message_channel uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_thread_id      (in_thread_id),
    .in_send_data      (in_send_data),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_target_thread (out_target_thread),
    .out_recv_data     (out_recv_data),
    .out_last          (out_last),
    .out_quiescent     (out_quiescent),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  channel_scoreboard scoreboard (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_thread_id      (in_thread_id),
    .in_send_data      (in_send_data),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_target_thread (out_target_thread),
    .out_recv_data     (out_recv_data),
    .out_last          (out_last),
    .out_quiescent     (out_quiescent),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .pending_results   (pending_results),
    .mismatch_count    (mismatch_count)
  );

  function automatic logic [PORT_W-1:0] pick_message();
    case ($urandom_range(0, 9))
      0: pick_message = '0;
      1: pick_message = '1;
      default: pick_message = {$urandom, $urandom};
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic drive_request(op_t op, logic [TID_W-1:0] tid, logic [PORT_W-1:0] msg);
    start <= 1'b1;
    in_op <= op;
    in_thread_id <= tid;
    in_send_data <= msg;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    in_op <= op_t'($urandom_range(0, 1));
    in_send_data <= {$urandom, $urandom};
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_channel();
    if (start) start <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] value);
    drain_channel();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int   gap_pct;
    int   burst_left;
    op_t  burst_op;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // rendezvous handoffs both ways
    set_capacity(0);
    drive_request(OP_SEND, 4'd0, '1);
    drive_request(OP_RECV, 4'd15, {$urandom, $urandom});
    drive_request(OP_RECV, 4'd3, '1);
    drive_request(OP_SEND, 4'd5, '0);
    drive_request(OP_RECV, 4'd7, '0);
    // parked receiver gets served through the ring
    set_capacity(2);
    drive_request(OP_SEND, 4'd1, 64'h8000_0000_0000_0001);
    drive_request(OP_SEND, 4'd2, 64'h5555_5555_5555_5555);
    drive_request(OP_SEND, 4'd4, 64'hAAAA_AAAA_AAAA_AAAA);
    drive_request(OP_SEND, 4'd6, 64'h0123_4567_89AB_CDEF);
    drive_request(OP_RECV, 4'd8, '1);
    // capacity lowered below fill
    set_capacity(1);
    drive_request(OP_SEND, 4'd9, 64'hFEDC_BA98_7654_3210);
    drive_request(OP_RECV, 4'd10, '0);
    // rendezvous with data still buffered; same thread parks twice
    set_capacity(0);
    drive_request(OP_RECV, 4'd11, '0);
    drive_request(OP_RECV, 4'd11, '1);
    // above ring depth acts as full depth
    set_capacity(31);
    drive_request(OP_SEND, 4'd12, 64'h7FFF_FFFF_FFFF_FFFE);
    drive_request(OP_SEND, 4'd13, 64'h0000_0001_0000_0000);
    drive_request(OP_SEND, 4'd14, 64'hC3C3_C3C3_3C3C_3C3C);
    drive_request(OP_RECV, 4'd14, '0);
    drive_request(OP_RECV, 4'd15, '0);
    drive_request(OP_RECV, 4'd15, '1);
    drive_request(OP_SEND, 4'd0, 64'h0F0F_0F0F_F0F0_F0F0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_capacity(phase_capacity[ph]);
      gap_pct = (ph >= NUM_PHASES - 2 || ph % 3 == 1) ? 0 : 30;
      // open each phase with a long run of one kind to push toward the queue limits
      burst_op = op_t'($urandom_range(0, 1));
      burst_left = $urandom_range(17, 20);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (burst_left == 0) begin
          burst_op = op_t'($urandom_range(0, 1));
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20)
                                                   : $urandom_range(1, 4);
        end
        burst_left--;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
          idle_cycles($urandom_range(1, 19));
        if (gap_pct != 0 && $urandom_range(0, 99) == 0)
          drain_channel();
        drive_request(burst_op, TID_W'($urandom_range(0, 15)), pick_message());
      end
    end

    drain_channel();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("blocking_message_channel verification clean");
    end else begin
      $display("blocking_message_channel verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("blocking_message_channel verification failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/bmc_pkg.sv
hw/rtl/bmc_ram.sv
hw/rtl/bmc_exec.sv
hw/rtl/blocking_message_channel.sv
test/channel_scoreboard.sv
test/testbench.sv
